// ===== design/h2r_pkg.sv =====
// Types, constants and helpers shared by the HSL to RGB percent converter.
// No dependencies.
package h2r_pkg;

    localparam logic [8:0] HUE_MAX = 9'd360;
    localparam logic [6:0] PCT_MAX = 7'd100;
    localparam logic [6:0] PCT_CAP = 7'd99;

    typedef struct packed {
        logic [8:0] hue_degrees;
        logic [6:0] saturation_pct;
        logic [6:0] lightness_pct;
    } hsl_word_t;

    typedef struct packed {
        logic [6:0] red_pct;
        logic [6:0] green_pct;
        logic [6:0] blue_pct;
    } rgb_word_t;

    typedef struct packed {
        logic [7:0] h8;
        logic [7:0] s8;
        logic [7:0] l8;
    } scaled_t;

    typedef struct packed {
        logic [7:0] v;
        logic [7:0] l8;
        logic [2:0] sext;
        logic [7:0] f;
    } peak_t;

    typedef struct packed {
        logic [7:0] v;
        logic [7:0] m;
        logic [7:0] d;
        logic [2:0] sext;
    } level_t;

    typedef struct packed {
        logic [7:0] v;
        logic [7:0] m;
        logic [7:0] mid1;
        logic [7:0] mid2;
        logic [2:0] sext;
    } mid_t;

    // x * 100 / 255, truncating; exact for x in 0..255
    function automatic logic [6:0] to_pct(input logic [7:0] x);
        logic [14:0] y;
        logic [14:0] sum;
        begin
            y   = 15'(x) * 15'd100;
            sum = y + (y >> 8) + 15'd1;
            return sum[14:8];
        end
    endfunction

endpackage

// ===== design/h2r_scale.sv =====
// Input stage: saturates hue, saturation and lightness and rescales them to 0..255.
// Depends on h2r_pkg.
module h2r_scale (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  h2r_pkg::hsl_word_t word,
    output logic               out_valid,
    output h2r_pkg::scaled_t   scaled
);
    import h2r_pkg::*;

    logic [8:0]  hue_sat;
    logic [6:0]  sat_sat;
    logic [6:0]  lit_sat;
    logic [12:0] hue_x17;
    logic [19:0] hue_q;
    logic [12:0] sat_x51;
    logic [12:0] lit_x51;
    logic [21:0] sat_q;
    logic [21:0] lit_q;
    logic        valid_reg;
    scaled_t     scaled_reg;
    scaled_t     scaled_next;

    always_comb
    begin
        hue_sat = (word.hue_degrees > HUE_MAX) ? HUE_MAX : word.hue_degrees;
        sat_sat = (word.saturation_pct > PCT_MAX) ? PCT_MAX : word.saturation_pct;
        lit_sat = (word.lightness_pct > PCT_MAX) ? PCT_MAX : word.lightness_pct;
        // h*255/360 = (h*17/8)/3 ; /3 via *683>>11
        hue_x17 = 13'(hue_sat) * 13'd17;
        hue_q   = 20'(hue_x17[12:3]) * 20'd683;
        // p*255/100 = (p*51/4)/5 ; /5 via *3277>>14
        sat_x51 = 13'(sat_sat) * 13'd51;
        lit_x51 = 13'(lit_sat) * 13'd51;
        sat_q   = 22'(sat_x51[12:2]) * 22'd3277;
        lit_q   = 22'(lit_x51[12:2]) * 22'd3277;
        scaled_next.h8 = hue_q[18:11];
        scaled_next.s8 = sat_q[21:14];
        scaled_next.l8 = lit_q[21:14];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            scaled_reg <= scaled_next;
        end
    end

    assign out_valid = valid_reg;
    assign scaled    = scaled_reg;

endmodule

// ===== design/h2r_level.sv =====
// Level stages: max level and sextant, then min level and interpolation term.
// Depends on h2r_pkg.
module h2r_level (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  h2r_pkg::scaled_t scaled,
    output logic             out_valid,
    output h2r_pkg::level_t  level
);
    import h2r_pkg::*;

    logic [15:0] ls_prod;
    logic [16:0] v_low;
    logic [16:0] v_high;
    logic [10:0] hue_x6;
    logic [8:0]  m_wide;
    logic [7:0]  m_val;
    logic [7:0]  span;
    logic [15:0] d_prod;
    logic        valid2_reg;
    logic        valid3_reg;
    peak_t       peak_reg;
    peak_t       peak_next;
    level_t      level_reg;
    level_t      level_next;

    always_comb
    begin
        ls_prod = 16'(scaled.l8) * 16'(scaled.s8);
        v_low   = {1'b0, scaled.l8, 8'd0} + 17'(ls_prod);
        v_high  = {(9'(scaled.l8) + 9'(scaled.s8)), 8'd0} - 17'(ls_prod);
        hue_x6  = 11'(scaled.h8) * 11'd6;
        peak_next.v    = scaled.l8[7] ? v_high[15:8] : v_low[15:8];
        peak_next.l8   = scaled.l8;
        peak_next.sext = hue_x6[10:8];
        peak_next.f    = hue_x6[7:0];
    end

    always_comb
    begin
        m_wide = {peak_reg.l8, 1'b0} - 9'(peak_reg.v);
        m_val  = m_wide[7:0];
        span   = peak_reg.v - m_val;
        d_prod = 16'(peak_reg.f) * 16'(span);
        level_next.v    = peak_reg.v;
        level_next.m    = m_val;
        level_next.d    = d_prod[15:8];
        level_next.sext = peak_reg.sext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else if (en)
        begin
            valid2_reg <= in_valid;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            peak_reg  <= peak_next;
            level_reg <= level_next;
        end
    end

    assign out_valid = valid3_reg;
    assign level     = level_reg;

endmodule

// ===== design/h2r_mix.sv =====
// Output stages: mid levels, percent rescale, sextant routing, full-duty cap.
// Depends on h2r_pkg.
module h2r_mix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               cap_full_duty,
    input  logic               in_valid,
    input  h2r_pkg::level_t    level,
    output logic               out_valid,
    output h2r_pkg::rgb_word_t word
);
    import h2r_pkg::*;

    logic       valid4_reg;
    logic       valid5_reg;
    mid_t       mid_reg;
    mid_t       mid_next;
    logic [6:0] v_pct;
    logic [6:0] m_pct;
    logic [6:0] mid1_pct;
    logic [6:0] mid2_pct;
    logic [6:0] r_sel;
    logic [6:0] g_sel;
    logic [6:0] b_sel;
    rgb_word_t  word_reg;
    rgb_word_t  word_next;

    always_comb
    begin
        mid_next.v    = level.v;
        mid_next.m    = level.m;
        mid_next.mid1 = level.m + level.d;
        mid_next.mid2 = level.v - level.d;
        mid_next.sext = level.sext;
    end

    always_comb
    begin
        v_pct    = to_pct(mid_reg.v);
        m_pct    = to_pct(mid_reg.m);
        mid1_pct = to_pct(mid_reg.mid1);
        mid2_pct = to_pct(mid_reg.mid2);
        case (mid_reg.sext)
            3'd0:
            begin
                r_sel = v_pct;    g_sel = mid1_pct; b_sel = m_pct;
            end
            3'd1:
            begin
                r_sel = mid2_pct; g_sel = v_pct;    b_sel = m_pct;
            end
            3'd2:
            begin
                r_sel = m_pct;    g_sel = v_pct;    b_sel = mid1_pct;
            end
            3'd3:
            begin
                r_sel = m_pct;    g_sel = mid2_pct; b_sel = v_pct;
            end
            3'd4:
            begin
                r_sel = mid1_pct; g_sel = m_pct;    b_sel = v_pct;
            end
            default:
            begin
                r_sel = v_pct;    g_sel = m_pct;    b_sel = mid2_pct;
            end
        endcase
        // black when the max level is zero
        if (mid_reg.v == 8'd0)
        begin
            r_sel = '0;
            g_sel = '0;
            b_sel = '0;
        end
        word_next.red_pct   = (cap_full_duty && r_sel == PCT_MAX) ? PCT_CAP : r_sel;
        word_next.green_pct = (cap_full_duty && g_sel == PCT_MAX) ? PCT_CAP : g_sel;
        word_next.blue_pct  = (cap_full_duty && b_sel == PCT_MAX) ? PCT_CAP : b_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid4_reg <= 1'b0;
            valid5_reg <= 1'b0;
        end
        else if (en)
        begin
            valid4_reg <= in_valid;
            valid5_reg <= valid4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mid_reg  <= mid_next;
            word_reg <= word_next;
        end
    end

    assign out_valid = valid5_reg;
    assign word      = word_reg;

endmodule

// ===== design/hsl_to_rgb_percent_top.sv =====
// HSL (degrees, percent) to RGB percent converter, top level.
// Depends on h2r_pkg, h2r_scale, h2r_level, h2r_mix.
//
// Takes one HSL word per clock while hsl_stall is low and returns one RGB word per
// input word, in order. The five register stages advance together; a
// stall on the rgb side while a word waits in the output register freezes the
// whole pipe and raises hsl_stall in the same cycle. Sustained rate is one word
// per cycle while rgb_stall is low. cap_full_duty resets to 1 and is written
// through cfg_we/cfg_wdata; change it only while no word is in flight.
module hsl_to_rgb_percent_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               hsl_valid,
    output logic               hsl_stall,
    input  h2r_pkg::hsl_word_t hsl_word,
    output logic               rgb_valid,
    input  logic               rgb_stall,
    output h2r_pkg::rgb_word_t rgb_word
);
    import h2r_pkg::*;

    logic    en;
    logic    cap_reg;
    logic    s1_valid;
    logic    s3_valid;
    scaled_t s1_word;
    level_t  s3_word;

    assign en        = !(rgb_valid && rgb_stall);
    assign hsl_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    h2r_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (hsl_valid),
        .word      (hsl_word),
        .out_valid (s1_valid),
        .scaled    (s1_word)
    );

    h2r_level u_level (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid),
        .scaled    (s1_word),
        .out_valid (s3_valid),
        .level     (s3_word)
    );

    h2r_mix u_mix (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .cap_full_duty (cap_reg),
        .in_valid      (s3_valid),
        .level         (s3_word),
        .out_valid     (rgb_valid),
        .word          (rgb_word)
    );

endmodule

// ===== design/h2r_checker.sv =====
// Port-level checks for the HSL to RGB percent converter, bound to the top level.
// Depends on h2r_pkg and hsl_to_rgb_percent_top.
module h2r_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_we,
    input logic               cfg_wdata,
    input logic               hsl_stall,
    input logic               rgb_valid,
    input logic               rgb_stall,
    input h2r_pkg::rgb_word_t rgb_word
);
    import h2r_pkg::*;

    logic cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            cap_reg <= cfg_wdata;
        end
    end

    // input side only backs up when the output word is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        hsl_stall |-> (rgb_valid && rgb_stall))
        else $error("hsl_stall without a held output word");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        rgb_valid |-> (rgb_word.red_pct <= PCT_MAX && rgb_word.green_pct <= PCT_MAX
                       && rgb_word.blue_pct <= PCT_MAX))
        else $error("rgb channel above 100");

    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (rgb_valid && cap_reg) |-> (rgb_word.red_pct != PCT_MAX
                                    && rgb_word.green_pct != PCT_MAX
                                    && rgb_word.blue_pct != PCT_MAX))
        else $error("full duty reported while capped");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rgb_valid && rgb_stall) |=> (rgb_valid && $stable(rgb_word)))
        else $error("stalled rgb word changed");

endmodule

bind hsl_to_rgb_percent_top h2r_checker u_h2r_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .hsl_stall (hsl_stall),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb_word  (rgb_word)
);

// ===== tb/tb_hsl_to_rgb_percent_top.sv =====
// Testbench for hsl_to_rgb_percent_top: random bursty HSL words in, stalled RGB words out,
// each RGB word checked against an integer sextant conversion computed in the bench.
// Depends on h2r_pkg and the hsl_to_rgb_percent_top RTL.
module tb_hsl_to_rgb_percent_top;
    timeunit 1ns;
    timeprecision 1ps;

    import h2r_pkg::*;

    localparam int  IDLE_LIMIT   = 2000;
    localparam int  DRAIN_CYCLES = 12;
    localparam logic CAP_OFF     = 1'b0;
    localparam logic CAP_ON      = 1'b1;

    typedef enum logic [2:0] {
        SX_RED_YELLOW,
        SX_YELLOW_GREEN,
        SX_GREEN_CYAN,
        SX_CYAN_BLUE,
        SX_BLUE_MAGENTA,
        SX_MAGENTA_RED
    } sextant_e;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we = 1'b0;
    logic      cfg_wdata = 1'b0;
    logic      hsl_valid = 1'b0;
    logic      hsl_stall;
    hsl_word_t hsl_word = '0;
    logic      rgb_valid;
    logic      rgb_stall = 1'b0;
    rgb_word_t rgb_word;

    hsl_word_t hsl_backlog[$];
    rgb_word_t rgb_due[$];
    logic      cap_on = CAP_ON;
    logic      steady = 1'b0;
    int        errors = 0;
    int        gap_left = 0;
    int        burst_left = 0;
    int        stall_run = 0;
    int        idle_cycles = 0;

    hsl_to_rgb_percent_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .hsl_valid (hsl_valid),
        .hsl_stall (hsl_stall),
        .hsl_word  (hsl_word),
        .rgb_valid (rgb_valid),
        .rgb_stall (rgb_stall),
        .rgb_word  (rgb_word)
    );

    always #5 clk = ~clk;

    function automatic logic [6:0] pct_of(input int unsigned x);
        return 7'((x * 100) / 255);
    endfunction

    function automatic logic [6:0] cap_level(input logic [6:0] x, input logic cap);
        if (cap == CAP_ON && x == PCT_MAX)
            return PCT_CAP;
        return x;
    endfunction

    function automatic rgb_word_t convert_hsl(input hsl_word_t w, input logic cap);
        int unsigned h, s, l, h8, s8, l8, v, m, p, f, d;
        logic [6:0] pv, pm, pmid1, pmid2;
        sextant_e   sx;
        rgb_word_t  o;
        h = (w.hue_degrees > HUE_MAX) ? HUE_MAX : w.hue_degrees;
        s = (w.saturation_pct > PCT_MAX) ? PCT_MAX : w.saturation_pct;
        l = (w.lightness_pct > PCT_MAX) ? PCT_MAX : w.lightness_pct;
        h8 = (h * 255) / 360;
        s8 = (s * 255) / 100;
        l8 = (l * 255) / 100;
        if (l8 < 128)
            v = (l8 * (256 + s8)) >> 8;
        else
            v = (((l8 + s8) << 8) - l8 * s8) >> 8;
        o = '0;
        if (v != 0)
        begin
            m = 2 * l8 - v;
            p = 6 * h8;
            sx = sextant_e'(p >> 8);
            f = p & 255;
            d = (f * (v - m)) >> 8;
            pmid1 = pct_of(m + d);
            pmid2 = pct_of(v - d);
            pv = pct_of(v);
            pm = pct_of(m);
            case (sx)
                SX_RED_YELLOW:   o = '{pv, pmid1, pm};
                SX_YELLOW_GREEN: o = '{pmid2, pv, pm};
                SX_GREEN_CYAN:   o = '{pm, pv, pmid1};
                SX_CYAN_BLUE:    o = '{pm, pmid2, pv};
                SX_BLUE_MAGENTA: o = '{pmid1, pm, pv};
                default:         o = '{pv, pm, pmid2};
            endcase
        end
        o.red_pct   = cap_level(o.red_pct, cap);
        o.green_pct = cap_level(o.green_pct, cap);
        o.blue_pct  = cap_level(o.blue_pct, cap);
        return o;
    endfunction

    task automatic check_field(input string name, input logic [6:0] exp_v,
                               input logic [6:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // sender: bursts of words separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsl_valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end
        else if (!hsl_valid || !hsl_stall)
        begin
            if (gap_left != 0 && !steady)
            begin
                hsl_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (hsl_backlog.size() != 0)
            begin
                hsl_word <= hsl_backlog.pop_front();
                hsl_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                    gap_left <= 0;
                end
            end
            else
                hsl_valid <= 1'b0;
        end
    end

    // receiver: stall in runs of random length
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            rgb_stall <= steady ? 1'b0 : ($urandom_range(0, 2) == 0);
            stall_run <= $urandom_range(1, 8);
        end
        else
            stall_run <= stall_run - 1;
    end

    // result check, then expectation for the word accepted at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rgb_valid && !rgb_stall)
            begin
                if (rgb_due.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, got %0d/%0d/%0d", $time,
                             rgb_word.red_pct, rgb_word.green_pct, rgb_word.blue_pct);
                    errors++;
                end
                else
                begin
                    rgb_word_t exp_w;
                    exp_w = rgb_due.pop_front();
                    check_field("red_pct", exp_w.red_pct, rgb_word.red_pct);
                    check_field("green_pct", exp_w.green_pct, rgb_word.green_pct);
                    check_field("blue_pct", exp_w.blue_pct, rgb_word.blue_pct);
                end
            end
            if (hsl_valid && !hsl_stall)
                rgb_due.push_back(convert_hsl(hsl_word, cap_on));
        end
    end

    always @(posedge clk)
    begin
        if ((hsl_valid && !hsl_stall) || (rgb_valid && !rgb_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic queue_word(input int h, input int s, input int l);
        hsl_word_t w;
        w.hue_degrees = 9'(h);
        w.saturation_pct = 7'(s);
        w.lightness_pct = 7'(l);
        hsl_backlog.push_back(w);
    endtask

    task automatic queue_directed();
        int hues[9] = '{0, 60, 120, 180, 240, 300, 360, 361, 511};
        foreach (hues[i])
            queue_word(hues[i], 100, 50);
        queue_word(30, 0, 50);
        queue_word(200, 100, 0);
        queue_word(200, 100, 100);
        queue_word(90, 127, 127);
        queue_word(45, 101, 1);
        queue_word(330, 1, 99);
        queue_word(15, 64, 64);
        queue_word(511, 127, 0);
        queue_word(359, 100, 49);
    endtask

    task automatic queue_random(input int count);
        int h, s, l;
        repeat (count)
        begin
            h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 360);
            s = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100);
            l = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 100);
            queue_word(h, s, l);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (hsl_backlog.size() != 0 || hsl_valid || rgb_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_cap(input logic val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        cap_on = val;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_directed();
        queue_random(150);
        wait_drained();

        write_cap(CAP_OFF);
        queue_directed();
        queue_random(200);
        wait_drained();

        write_cap(CAP_ON);
        steady = 1'b1;
        queue_random(150);
        wait_drained();
        steady = 1'b0;

        write_cap(CAP_OFF);
        queue_random(150);
        wait_drained();

        write_cap(CAP_ON);
        queue_random(150);
        wait_drained();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
